### src/hsfd_pkg.sv
// Humidity sensor frame decoder: shared package.
// Frame positions, status codes, record types, CRC-8 step and scaling constants.
// No dependencies.
`default_nettype none

package hsfd_pkg;

   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [14:0] TEMP_SCALE  = 15'd17500;
   localparam logic [13:0] HUM_SCALE   = 14'd10000;
   localparam logic [15:0] TEMP_OFFSET = 16'd4500;
   localparam logic [16:0] DIV_CONST   = 17'd65535;
   localparam int          QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      POS_T_HI  = 3'd0,
      POS_T_LO  = 3'd1,
      POS_T_CRC = 3'd2,
      POS_H_HI  = 3'd3,
      POS_H_LO  = 3'd4,
      POS_H_CRC = 3'd5
   } pos_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_T_CRC = 2'd1,
      STATUS_H_CRC = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] raw_t;
      logic [15:0] raw_h;
   } frame_rec_type;

   typedef struct packed {
      logic          valid;
      frame_rec_type rec;
   } push_type;

   typedef struct packed {
      logic full;
   } queue_stat_type;

   // One byte of CRC-8, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### src/hsfd_front.sv
// Humidity sensor frame decoder: front end.
// Tracks byte position, running CRC and assembled words; pushes one record per frame.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_front
   import hsfd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [7:0]     req_rx_byte,
   input  wire logic           req_frame_start,
   input  wire queue_stat_type q_stat,
   output push_type            push
);

   pos_type     pos_ff, pos_in, pos_cur;
   logic [7:0]  crc_ff, crc_in, crc_base, crc_next;
   logic [7:0]  word_high_ff, word_high_in;
   logic [15:0] held_t_ff, held_t_in;
   logic [15:0] held_h_ff, held_h_in;
   logic        t_bad_ff, t_bad_in;
   logic        take;
   logic        resync;

   assign req_ready = !q_stat.full;
   assign take      = req_valid && req_ready;
   assign resync    = req_frame_start || (pos_ff > POS_H_CRC);
   assign pos_cur   = resync ? POS_T_HI : pos_ff;
   assign crc_base  = resync ? CRC_INIT : crc_ff;
   assign crc_next  = crc8_byte(crc_base, req_rx_byte);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      word_high_in = word_high_ff;
      held_t_in    = held_t_ff;
      held_h_in    = held_h_ff;
      t_bad_in     = t_bad_ff;
      push.valid   = 1'b0;
      push.rec     = '{status: STATUS_OK, raw_t: held_t_ff, raw_h: held_h_ff};
      if (take) begin
         unique case (pos_cur)
            POS_T_HI: begin
               crc_in       = crc_next;
               word_high_in = req_rx_byte;
               pos_in       = POS_T_LO;
            end
            POS_T_LO: begin
               crc_in    = crc_next;
               held_t_in = {word_high_ff, req_rx_byte};
               pos_in    = POS_T_CRC;
            end
            POS_T_CRC: begin
               t_bad_in = (crc_base != req_rx_byte);
               crc_in   = CRC_INIT;
               pos_in   = POS_H_HI;
            end
            POS_H_HI: begin
               crc_in       = crc_next;
               word_high_in = req_rx_byte;
               pos_in       = POS_H_LO;
            end
            POS_H_LO: begin
               crc_in    = crc_next;
               held_h_in = {word_high_ff, req_rx_byte};
               pos_in    = POS_H_CRC;
            end
            POS_H_CRC: begin
               push.valid = 1'b1;
               if (t_bad_ff) begin
                  push.rec.status = STATUS_T_CRC;
               end else if (crc_base != req_rx_byte) begin
                  push.rec.status = STATUS_H_CRC;
               end else begin
                  push.rec.status = STATUS_OK;
               end
               crc_in = CRC_INIT;
               pos_in = POS_T_HI;
            end
            default: begin
               pos_in = POS_T_HI;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_T_HI;
         crc_ff       <= CRC_INIT;
         word_high_ff <= '0;
         held_t_ff    <= '0;
         held_h_ff    <= '0;
         t_bad_ff     <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         word_high_ff <= word_high_in;
         held_t_ff    <= held_t_in;
         held_h_ff    <= held_h_in;
         t_bad_ff     <= t_bad_in;
      end
   end

endmodule

`default_nettype wire

### src/hsfd_queue.sv
// Humidity sensor frame decoder: two-entry record queue between front and back.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_queue
   import hsfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire push_type  push,
   output queue_stat_type q_stat,
   output logic           q_valid,
   output frame_rec_type  q_rec,
   input  wire logic      q_pop
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   frame_rec_type   entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign q_valid     = (count_ff != '0);
   assign q_rec       = entry_ff[rd_ptr_ff];
   assign q_stat.full = (count_ff == CntW'(QUEUE_DEPTH));
   assign do_push     = push.valid && !q_stat.full;
   assign do_pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.rec;
      end
   end

endmodule

`default_nettype wire

### src/hsfd_back.sv
// Humidity sensor frame decoder: back end.
// Stage 1 multiplies raw words by scale; stage 2 divides by 65535 and drives the result register.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_back
   import hsfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire frame_rec_type q_rec,
   output logic               q_pop,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [14:0]        rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_raw_temperature,
   output logic [15:0]        rsp_raw_humidity
);

   logic          s1_valid_ff, s1_valid_in;
   frame_rec_type s1_rec_ff;
   logic [30:0]   t_prod_ff;
   logic [29:0]   h_prod_ff;
   logic          out_valid_ff, out_valid_in;
   logic          out_adv, s1_load;

   logic [14:0]   t_q;
   logic [13:0]   h_q;
   logic [16:0]   t_rem, h_rem;
   logic [14:0]   t_div;
   logic [13:0]   h_div;
   logic [15:0]   t_signed;

   logic [1:0]    status_ff;
   logic [14:0]   temp_ff;
   logic [13:0]   hum_ff;
   logic [15:0]   raw_t_ff, raw_h_ff;

   assign out_adv      = !out_valid_ff || rsp_ready;
   assign s1_load      = !s1_valid_ff || out_adv;
   assign q_pop        = q_valid && s1_load;
   assign s1_valid_in  = s1_load ? q_valid : s1_valid_ff;
   assign out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;

   // x / 65535 with x = q*65536 + lo: remainder q + lo stays below 2*65535.
   assign t_q      = t_prod_ff[30:16];
   assign h_q      = h_prod_ff[29:16];
   assign t_rem    = 17'(t_q) + 17'(t_prod_ff[15:0]);
   assign h_rem    = 17'(h_q) + 17'(h_prod_ff[15:0]);
   assign t_div    = t_q + 15'(t_rem >= DIV_CONST);
   assign h_div    = h_q + 14'(h_rem >= DIV_CONST);
   assign t_signed = 16'(t_div) - TEMP_OFFSET;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_rec_ff <= q_rec;
         t_prod_ff <= 31'(TEMP_SCALE) * 31'(q_rec.raw_t);
         h_prod_ff <= 30'(HUM_SCALE) * 30'(q_rec.raw_h);
      end
      if (out_adv && s1_valid_ff) begin
         status_ff <= s1_rec_ff.status;
         temp_ff   <= t_signed[14:0];
         hum_ff    <= h_div;
         raw_t_ff  <= s1_rec_ff.raw_t;
         raw_h_ff  <= s1_rec_ff.raw_h;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_status            = status_ff;
   assign rsp_temperature_centi = temp_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_raw_temperature   = raw_t_ff;
   assign rsp_raw_humidity      = raw_h_ff;

endmodule

`default_nettype wire

### src/humidity_sensor_frame_decoder_unit.sv
// Humidity sensor frame decoder: top level.
// Connects front end, record queue and back end. Depends on hsfd_pkg and the three submodules.
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_ready  | rx_byte[7:0], frame_start
//   rsp_     | out       | rsp_valid/rsp_ready  | status, temperature_centi, humidity_centi,
//            |           |                      | raw_temperature, raw_humidity
//
// One byte is taken per cycle while req_ready is high. The sixth byte of a frame pushes a
// record through the queue, the multiply stage and the divide stage into the result register.
// Synchronous reset returns position to the first byte and the CRC to 0xFF; no clearing pass.
// A stalled result holds the back end; the two-entry queue then fills and req_ready falls.
`default_nettype none

module humidity_sensor_frame_decoder_unit
   import hsfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [14:0]      rsp_temperature_centi,
   output logic [13:0]      rsp_humidity_centi,
   output logic [15:0]      rsp_raw_temperature,
   output logic [15:0]      rsp_raw_humidity
);

   push_type       push;
   queue_stat_type q_stat;
   logic           q_valid;
   frame_rec_type  q_rec;
   logic           q_pop;

   hsfd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .req_frame_start (req_frame_start),
      .q_stat          (q_stat),
      .push            (push)
   );

   hsfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_stat  (q_stat),
      .q_valid (q_valid),
      .q_rec   (q_rec),
      .q_pop   (q_pop)
   );

   hsfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_rec                 (q_rec),
      .q_pop                 (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_raw_temperature   (rsp_raw_temperature),
      .rsp_raw_humidity      (rsp_raw_humidity)
   );

endmodule

`default_nettype wire

### src/hsfd_checker.sv
// Humidity sensor frame decoder: port-level checker and its bind to the top level.
// Depends on hsfd_pkg.
`default_nettype none

module hsfd_checker
   import hsfd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [14:0] rsp_temperature_centi,
   input wire logic [13:0] rsp_humidity_centi,
   input wire logic [15:0] rsp_raw_temperature,
   input wire logic [15:0] rsp_raw_humidity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_temperature)
                                  && $stable(rsp_raw_humidity))
      else $error("result dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK) || (rsp_status == STATUS_T_CRC)
                    || (rsp_status == STATUS_H_CRC))
      else $error("invalid status code");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_humidity_centi <= 14'd10000)
      else $error("humidity out of range");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_temperature_centi) >= -15'sd4500)
                    && ($signed(rsp_temperature_centi) <= 15'sd13000))
      else $error("temperature out of range");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind humidity_sensor_frame_decoder_unit hsfd_checker u_hsfd_checker (.*);

`default_nettype wire

### tb/tb_humidity_sensor_frame_decoder_unit.sv
// Testbench for humidity_sensor_frame_decoder_unit: directed frames, then random frames.
// Random frames are checked against a byte-level decoder model kept here, directed ones against the table.
// Depends on hsfd_pkg and the RTL top level.
`default_nettype none

module tb_humidity_sensor_frame_decoder_unit;
   import hsfd_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_BYTES   = 300;
   localparam int HOLD_CYCLES   = 80;
   localparam int DIRECTED_ROWS = 26;

   typedef struct packed {
      status_type  status;
      logic [14:0] temp;
      logic [13:0] hum;
      logic [15:0] raw_t;
      logic [15:0] raw_h;
   } frame_result;

   typedef struct packed {
      logic [7:0]  b;
      logic        start;
      logic        typed;
      frame_result exp;
   } byte_row;

   localparam frame_result NO_RES  = '0;
   localparam frame_result ZERO_OK = '{STATUS_OK, -15'sd4500, 14'd0, 16'h0000, 16'h0000};
   localparam frame_result BOTH_BAD = '{STATUS_T_CRC, -15'sd4500, 14'd0, 16'h0000, 16'h0000};
   localparam frame_result FULL_OK = '{STATUS_OK, 15'd13000, 14'd10000, 16'hFFFF, 16'hFFFF};
   localparam frame_result HUM_BAD = '{STATUS_H_CRC, 15'd13000, 14'd10000, 16'hFFFF, 16'hFFFF};

   // all-zero frame, full-scale frame with bad humidity CRC, both CRCs bad,
   // aborted frame, resync into a full-scale frame
   localparam byte_row DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{8'h00, 1'b1, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h81, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h81, 1'b0, 1'b1, ZERO_OK},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'hAC, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b1, HUM_BAD},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b0, NO_RES},
      '{8'h00, 1'b0, 1'b0, NO_RES}, '{8'h00, 1'b0, 1'b1, BOTH_BAD},
      '{8'h12, 1'b1, 1'b0, NO_RES}, '{8'h34, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b1, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'hAC, 1'b0, 1'b0, NO_RES}, '{8'hFF, 1'b0, 1'b0, NO_RES},
      '{8'hFF, 1'b0, 1'b0, NO_RES}, '{8'hAC, 1'b0, 1'b1, FULL_OK}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [14:0] rsp_temperature_centi;
   logic [13:0] rsp_humidity_centi;
   logic [15:0] rsp_raw_temperature;
   logic [15:0] rsp_raw_humidity;

   // side band carried with each offered byte
   logic        req_typed = 1'b0;
   frame_result req_expect = '0;

   // decoder model state
   logic [2:0]  frame_pos = POS_T_HI;
   logic [7:0]  word_crc = CRC_INIT;
   logic [7:0]  word_hi = 8'h00;
   logic [15:0] temp_word = 16'h0000;
   logic [15:0] hum_word = 16'h0000;
   logic        temp_crc_bad = 1'b0;

   frame_result pending_frames[$];
   frame_result predicted;
   frame_result want;

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;
   int stall_cycles = 0;
   int errors = 0;
   int bytes_sent = 0;
   int frames_seen = 0;
   int status_seen [3] = '{0, 0, 0};

   humidity_sensor_frame_decoder_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_temperature_centi(rsp_temperature_centi),
      .rsp_humidity_centi(rsp_humidity_centi),
      .rsp_raw_temperature(rsp_raw_temperature),
      .rsp_raw_humidity(rsp_raw_humidity)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // CRC-8 fold of one byte, bit-serial form
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

   // advances the frame state by one byte; returns 1 when a frame completes
   function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                      output frame_result r);
      logic [2:0]  p;
      int unsigned t_scaled;
      int unsigned h_scaled;
      int          t_centi;
      r = '0;
      p = frame_pos;
      if (fs || p > POS_H_CRC) begin
         p = POS_T_HI;
         word_crc = CRC_INIT;
      end
      case (p)
         POS_T_HI, POS_H_HI: begin
            word_crc = crc8_step(word_crc, b);
            word_hi = b;
            frame_pos = p + 3'd1;
            return 1'b0;
         end
         POS_T_LO: begin
            word_crc = crc8_step(word_crc, b);
            temp_word = {word_hi, b};
            frame_pos = POS_T_CRC;
            return 1'b0;
         end
         POS_H_LO: begin
            word_crc = crc8_step(word_crc, b);
            hum_word = {word_hi, b};
            frame_pos = POS_H_CRC;
            return 1'b0;
         end
         POS_T_CRC: begin
            temp_crc_bad = (word_crc != b);
            word_crc = CRC_INIT;
            frame_pos = POS_H_HI;
            return 1'b0;
         end
         default: begin
            if (temp_crc_bad) begin
               r.status = STATUS_T_CRC;
            end else if (word_crc != b) begin
               r.status = STATUS_H_CRC;
            end else begin
               r.status = STATUS_OK;
            end
            word_crc = CRC_INIT;
            frame_pos = POS_T_HI;
            t_scaled = (17500 * temp_word) / 65535;
            h_scaled = (10000 * hum_word) / 65535;
            t_centi = int'(t_scaled) - 4500;
            r.temp = t_centi[14:0];
            r.hum = h_scaled[13:0];
            r.raw_t = temp_word;
            r.raw_h = hum_word;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      int k;
      k = $urandom_range(9);
      if (k == 0) begin
         return 16'h0000;
      end else if (k == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom);
   endfunction

   task automatic offer(input logic [7:0] b, input logic fs, input logic typed,
                        input frame_result e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= fs;
      req_typed <= typed;
      req_expect <= e;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (decode_byte(req_rx_byte, req_frame_start, predicted)) begin
               pending_frames.push_back(req_typed ? req_expect : predicted);
            end
         end
         if (rsp_valid && rsp_ready) begin
            frames_seen++;
            if (rsp_status < 2'd3) begin
               status_seen[rsp_status]++;
            end
            if (pending_frames.size() == 0) begin
               $error("result with no frame pending: status %0d raw %h %h",
                      rsp_status, rsp_raw_temperature, rsp_raw_humidity);
               errors++;
            end else begin
               want = pending_frames.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_temperature_centi !== want.temp) begin
                  $error("temperature_centi: expected %0d, got %0d",
                         $signed(want.temp), $signed(rsp_temperature_centi));
                  errors++;
               end
               if (rsp_humidity_centi !== want.hum) begin
                  $error("humidity_centi: expected %0d, got %0d",
                         want.hum, rsp_humidity_centi);
                  errors++;
               end
               if (rsp_raw_temperature !== want.raw_t) begin
                  $error("raw_temperature: expected %h, got %h",
                         want.raw_t, rsp_raw_temperature);
                  errors++;
               end
               if (rsp_raw_humidity !== want.raw_h) begin
                  $error("raw_humidity: expected %h, got %h",
                         want.raw_h, rsp_raw_humidity);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("[humidity_sensor_frame_decoder_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0]  frame [6];
      logic [15:0] rt;
      logic [15:0] rh;
      logic        resync;
      int          kind;
      int          sent;
      int          n;

      resync = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      rsp_idle_pct = 66;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         offer(DIRECTED[i].b, DIRECTED[i].start, DIRECTED[i].typed, DIRECTED[i].exp);
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 17;
               rsp_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               rsp_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
               hold_left = HOLD_CYCLES;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 80) begin
               rt = pick_word();
               rh = pick_word();
               frame[0] = rt[15:8];
               frame[1] = rt[7:0];
               frame[2] = crc8_step(crc8_step(CRC_INIT, rt[15:8]), rt[7:0]);
               frame[3] = rh[15:8];
               frame[4] = rh[7:0];
               frame[5] = crc8_step(crc8_step(CRC_INIT, rh[15:8]), rh[7:0]);
               if ($urandom_range(99) < 15) begin
                  frame[2] = 8'($urandom);
               end
               if ($urandom_range(99) < 15) begin
                  frame[5] = 8'($urandom);
               end
               for (int i = 0; i < 6; i++) begin
                  offer(frame[i], (i == 0) && (resync || $urandom_range(1)), 1'b0, NO_RES);
               end
               resync = 1'b0;
               sent += 6;
            end else if (kind < 90) begin
               // aborted frame
               n = $urandom_range(1, 5);
               for (int i = 0; i < n; i++) begin
                  offer(8'($urandom), i == 0, 1'b0, NO_RES);
               end
               resync = 1'b1;
               sent += n;
            end else begin
               offer(8'($urandom), 1'($urandom_range(1)), 1'b0, NO_RES);
               resync = 1'b1;
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_frames.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("sent %0d bytes in directed and random frames under three stall patterns",
               bytes_sent);
      $display("checked %0d frames: ok %0d, temperature CRC %0d, humidity CRC %0d",
               frames_seen, status_seen[0], status_seen[1], status_seen[2]);
      if (errors == 0) begin
         $display("[humidity_sensor_frame_decoder_unit] OK");
      end else begin
         $display("[humidity_sensor_frame_decoder_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
